// ----- hdl/gpawb_pkg.sv -----
// Shared types, codes and helpers for the grey-point auto white balance block.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps
package gpawb_pkg;

  localparam logic [1:0] ST_CONVERGED = 2'd0;
  localparam logic [1:0] ST_NO_GREY   = 2'd1;
  localparam logic [1:0] ST_LIMIT     = 2'd2;
  localparam logic [1:0] ST_READOUT   = 2'd3;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_GAIN_STEP = 1'b1;

  localparam logic signed [15:0] GAIN_ONE = 16'sd4096;
  localparam int ITER_W = 8;

  typedef struct packed {
    logic       load;
    logic       read_start;
    logic       pass_start;
    logic       issue;
    logic       dec_prep;
    logic       decide;
    logic       res_write;
    logic       res_read;
    logic [1:0] res_status;
    logic [6:0] res_iter;
  } gpawb_cmd_t;

  typedef struct packed {
    logic       issue_done;
    logic       pipe_busy;
    logic       stop;
    logic [1:0] stop_status;
    logic       out_free;
  } gpawb_stat_t;

  // Gain multiply: non-positive products give 0, the rest drop 12 fraction bits
  // and clip at 255.
  function automatic logic [7:0] apply_gain(logic [7:0] v, logic signed [15:0] g);
    logic signed [24:0] p;
    p = $signed({1'b0, v}) * g;
    if (p <= 0) begin
      return 8'd0;
    end else if (p[24:12] > 13'd255) begin
      return 8'd255;
    end else begin
      return p[19:12];
    end
  endfunction

endpackage

// ----- hdl/gpawb_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
module gpawb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/gpawb_datapath.sv -----
// Datapath: image store, gain pipeline, grey-point accumulators, gain update and
// the output register. Depends on gpawb_pkg and gpawb_ram.
`timescale 1ns / 1ps
module gpawb_datapath
  import gpawb_pkg::*;
#(
  parameter int MAX_PIXELS = 16384
) (
  input  logic         clk,
  input  logic         rst,
  input  gpawb_cmd_t   cmd,
  output gpawb_stat_t  stat,
  input  logic [15:0]  grey_threshold,
  input  logic [11:0]  gain_step,
  input  logic [39:0]  in_data,
  input  logic         in_last,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [1:0]   out_status,
  output logic [79:0]  out_data
);

  localparam int AW = $clog2(MAX_PIXELS);
  localparam int CW = AW + 1;
  localparam int SW = AW + 21;
  localparam int IW = (CW > 15) ? CW : 15;

  logic [CW-1:0] pixel_count, addr, grey_n;
  logic          image_closed;
  logic signed [15:0] wg [3];
  logic signed [15:0] ag [3];
  logic signed [SW-1:0] sum_u, sum_v;
  logic t1, t2, t3, t4;
  logic [7:0] s1_b, s1_g, s1_r;
  logic signed [19:0] s2_y, s2_u, s2_v, s3_u, s3_v;
  logic [33:0] s3_lhs, s3_rhs;
  logic [SW-1:0] au, av, n800, n150;
  logic rd_oob;
  logic [23:0] rdata;

  // Load side
  logic [CW-1:0] cnt_eff;
  logic          we;
  logic [IW-1:0] idx_ext;
  assign cnt_eff = image_closed ? '0 : pixel_count;
  assign we      = cmd.load && (cnt_eff < CW'(MAX_PIXELS));
  assign idx_ext = IW'(in_data[37:24]);

  gpawb_ram #(.WIDTH(24), .DEPTH(MAX_PIXELS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (cnt_eff[AW-1:0]),
    .wdata (in_data[23:0]),
    .re    (cmd.read_start | cmd.issue),
    .raddr (cmd.read_start ? idx_ext[AW-1:0] : addr[AW-1:0]),
    .rdata (rdata)
  );

  // Stage 2 and 3 arithmetic
  logic signed [19:0] rr, gg, bb, u_abs, v_abs;
  logic [19:0] auv;
  always_comb begin
    rr = {12'd0, s1_r};
    gg = {12'd0, s1_g};
    bb = {12'd0, s1_b};
    u_abs = s2_u[19] ? -s2_u : s2_u;
    v_abs = s2_v[19] ? -s2_v : s2_v;
    auv = 20'(u_abs) + 20'(v_abs);
  end

  // Decision on the registered absolute sums
  logic sel_blue, sel_red;
  logic [SW-1:0] as_sel;
  logic s_pos, full_step;
  logic signed [17:0] delta, g_new;
  logic signed [15:0] g_sel, g_sat;
  always_comb begin
    stat.issue_done = addr == pixel_count;
    stat.pipe_busy  = t1 | t2 | t3 | t4;
    stat.out_free   = !out_valid || out_ready;
    sel_blue = (au > av) || ((au == av) && (au != '0));
    sel_red  = au < av;
    as_sel   = sel_blue ? au : av;
    s_pos    = sel_blue ? !sum_u[SW-1] : !sum_v[SW-1];
    full_step = as_sel >= n800;
    stat.stop = 1'b1;
    stat.stop_status = ST_CONVERGED;
    if (grey_n == '0) begin
      stat.stop_status = ST_NO_GREY;
    end else if (sel_blue || sel_red) begin
      stat.stop = as_sel < n150;
    end
    delta = full_step ? 18'({gain_step, 1'b0}) : 18'(gain_step >> 1);
    if (s_pos) begin
      delta = -delta;
    end
    g_sel = sel_blue ? wg[0] : wg[2];
    g_new = 18'(g_sel) + delta;
    if (g_new > 18'sd32767) begin
      g_sat = 16'sd32767;
    end else if (g_new < -18'sd32768) begin
      g_sat = -16'sd32768;
    end else begin
      g_sat = g_new[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_count  <= '0;
      image_closed <= 1'b0;
      addr  <= '0;
      grey_n <= '0;
      sum_u <= '0;
      sum_v <= '0;
      t1 <= 1'b0;
      t2 <= 1'b0;
      t3 <= 1'b0;
      t4 <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        wg[i] <= GAIN_ONE;
        ag[i] <= GAIN_ONE;
      end
    end else begin
      if (cmd.load) begin
        image_closed <= 1'b0;
        pixel_count  <= cnt_eff + CW'(we);
        if (image_closed || in_last) begin
          for (int i = 0; i < 3; i++) begin
            wg[i] <= GAIN_ONE;
            ag[i] <= GAIN_ONE;
          end
        end
      end
      if (cmd.pass_start) begin
        for (int i = 0; i < 3; i++) begin
          ag[i] <= wg[i];
        end
        addr   <= '0;
        grey_n <= '0;
        sum_u  <= '0;
        sum_v  <= '0;
      end
      if (cmd.issue) begin
        addr <= addr + 1'b1;
      end
      t1 <= cmd.issue;
      t2 <= t1;
      t3 <= t2;
      t4 <= t3;
      if (t4 && (s3_lhs < s3_rhs)) begin
        sum_u  <= sum_u + SW'(s3_u);
        sum_v  <= sum_v + SW'(s3_v);
        grey_n <= grey_n + 1'b1;
      end
      if (cmd.decide && !stat.stop) begin
        if (sel_blue) begin
          wg[0] <= g_sat;
        end else begin
          wg[2] <= g_sat;
        end
      end
      if (cmd.res_write) begin
        out_valid <= 1'b1;
        if (!cmd.res_read) begin
          image_closed <= 1'b1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    s1_b <= apply_gain(rdata[7:0], ag[0]);
    s1_g <= apply_gain(rdata[15:8], ag[1]);
    s1_r <= apply_gain(rdata[23:16], ag[2]);
    s2_y <= 20'sd299 * rr + 20'sd587 * gg + 20'sd114 * bb;
    s2_u <= 20'sd886 * bb - 20'sd299 * rr - 20'sd587 * gg;
    s2_v <= 20'sd701 * rr - 20'sd587 * gg - 20'sd114 * bb;
    s3_u <= s2_u;
    s3_v <= s2_v;
    s3_lhs <= {2'b00, auv, 12'd0};
    s3_rhs <= grey_threshold * s2_y[17:0];
    if (cmd.read_start) begin
      rd_oob <= !(idx_ext < IW'(pixel_count));
    end
    if (cmd.dec_prep) begin
      au   <= sum_u[SW-1] ? SW'(-sum_u) : SW'(sum_u);
      av   <= sum_v[SW-1] ? SW'(-sum_v) : SW'(sum_v);
      n800 <= {{(SW-CW){1'b0}}, grey_n} * SW'(800);
      n150 <= {{(SW-CW){1'b0}}, grey_n} * SW'(150);
    end
    if (cmd.res_write) begin
      out_status <= cmd.res_status;
      out_data[79] <= 1'b0;
      out_data[6:0] <= cmd.res_iter;
      if (cmd.res_read) begin
        out_data[22:7]  <= ag[0];
        out_data[38:23] <= ag[1];
        out_data[54:39] <= ag[2];
        out_data[62:55] <= rd_oob ? 8'd0 : s1_b;
        out_data[70:63] <= rd_oob ? 8'd0 : s1_g;
        out_data[78:71] <= rd_oob ? 8'd0 : s1_r;
      end else begin
        out_data[22:7]  <= wg[0];
        out_data[38:23] <= wg[1];
        out_data[54:39] <= wg[2];
        out_data[78:55] <= '0;
      end
    end
  end

endmodule

// ----- hdl/gpawb_ctrl.sv -----
// Controller: sequences loads, readouts and the balancing passes.
// Depends on gpawb_pkg.
`timescale 1ns / 1ps
module gpawb_ctrl
  import gpawb_pkg::*;
#(
  parameter int MAX_ITERATIONS = 100
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic        in_last,
  input  gpawb_stat_t stat,
  output gpawb_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_PASS, S_ISSUE, S_DRAIN, S_PREP, S_DECIDE, S_RD1, S_RESULT
  } state_t;

  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(MAX_ITERATIONS - 1);
  localparam logic [ITER_W-1:0] ITER_MAX  = ITER_W'(MAX_ITERATIONS);

  state_t state;
  logic [ITER_W-1:0] iter;
  logic [1:0] res_status;
  logic [6:0] res_iter;
  logic res_read;
  logic accept;

  assign in_ready = state == S_IDLE;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd = '0;
    cmd.load       = accept && (in_op == OP_LOAD);
    cmd.read_start = accept && (in_op == OP_READ);
    cmd.pass_start = state == S_PASS;
    cmd.issue      = (state == S_ISSUE) && !stat.issue_done;
    cmd.dec_prep   = state == S_PREP;
    cmd.decide     = state == S_DECIDE;
    cmd.res_write  = (state == S_RESULT) && stat.out_free;
    cmd.res_read   = res_read;
    cmd.res_status = res_status;
    cmd.res_iter   = res_iter;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      iter  <= '0;
      res_status <= ST_CONVERGED;
      res_iter <= '0;
      res_read <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.load && in_last) begin
            iter  <= '0;
            state <= S_PASS;
          end else if (cmd.read_start) begin
            res_read   <= 1'b1;
            res_status <= ST_READOUT;
            res_iter   <= '0;
            state      <= S_RD1;
          end
        end
        S_PASS:  state <= S_ISSUE;
        S_ISSUE: begin
          if (stat.issue_done) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!stat.pipe_busy) begin
            state <= S_PREP;
          end
        end
        S_PREP: state <= S_DECIDE;
        S_DECIDE: begin
          res_read <= 1'b0;
          if (stat.stop) begin
            res_status <= stat.stop_status;
            res_iter   <= iter[6:0];
            state      <= S_RESULT;
          end else if (iter == ITER_LAST) begin
            res_status <= ST_LIMIT;
            res_iter   <= ITER_MAX[6:0];
            state      <= S_RESULT;
          end else begin
            iter  <= iter + 1'b1;
            state <= S_PASS;
          end
        end
        // The pixel leaves the RAM here; the gain stage registers it next cycle.
        S_RD1: state <= S_RESULT;
        S_RESULT: begin
          if (stat.out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/grey_point_auto_white_balance.sv -----
// Top level of the grey-point auto white balance block: configuration registers,
// stream ports, controller and datapath. Depends on gpawb_pkg and its submodules.
//
//   channel  direction  handshake                 contents
//   s_*      in         s_tvalid / s_tready       pixel load or readout request
//   m_*      out        m_tvalid / m_tready       balance result or corrected pixel
//   apb      in/out     psel, penable (pready=1)  grey_threshold, gain_step
//
// A load without the last mark stores the pixel and leaves the block idle.
// A load marked last runs up to MAX_ITERATIONS passes, in each of which the
// single RAM read port streams one stored pixel per cycle into the grey test
// pipeline. A readout passes the stored pixel through the gain stage. Reset is
// synchronous and needs no clearing pass. A result waiting in the output register
// holds the block only when the next result is ready; plain loads are still taken.
`timescale 1ns / 1ps
module grey_point_auto_white_balance
  import gpawb_pkg::*;
#(
  parameter int MAX_PIXELS     = 16384,
  parameter int MAX_ITERATIONS = 100
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  // pixel_b, pixel_g, pixel_r, read_index, zero fill
  input  logic [39:0] s_tdata,
  // last_pixel
  input  logic        s_tlast,
  // op
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // iterations, gain_blue, gain_green, gain_red, out_b, out_g, out_r, zero fill
  output logic [79:0] m_tdata,
  // status
  output logic [1:0]  m_tuser
);

  logic [15:0] grey_threshold;
  logic [11:0] gain_step;
  gpawb_cmd_t  cmd;
  gpawb_stat_t stat;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_GAIN_STEP) ? {20'd0, gain_step} : {16'd0, grey_threshold};

  always_ff @(posedge clk) begin
    if (rst) begin
      grey_threshold <= 16'd1229;
      gain_step      <= 12'd128;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_THRESHOLD) begin
        grey_threshold <= pwdata[15:0];
      end else begin
        gain_step <= pwdata[11:0];
      end
    end
  end

  gpawb_ctrl #(.MAX_ITERATIONS(MAX_ITERATIONS)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_op    (s_tuser),
    .in_last  (s_tlast),
    .stat     (stat),
    .cmd      (cmd)
  );

  gpawb_datapath #(.MAX_PIXELS(MAX_PIXELS)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .grey_threshold (grey_threshold),
    .gain_step      (gain_step),
    .in_data        (s_tdata),
    .in_last        (s_tlast),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_status     (m_tuser),
    .out_data       (m_tdata)
  );

endmodule

// ----- hdl/gpawb_checker.sv -----
// Port-level checks for the grey-point auto white balance block, bound to the
// top level. Depends on gpawb_pkg.
`timescale 1ns / 1ps
module gpawb_checker
  import gpawb_pkg::*;
#(
  parameter int MAX_ITERATIONS = 100
) (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [79:0] m_tdata,
  input logic [1:0]  m_tuser
);

  localparam logic [6:0] ITER_MAX = 7'(MAX_ITERATIONS);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result shown straight after reset");

  a_read_iter: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_READOUT |-> m_tdata[6:0] == 7'd0)
    else $error("readout carries an iteration count");

  a_bal_pix: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_READOUT |-> m_tdata[78:55] == 24'd0)
    else $error("balance result carries pixel data");

  a_limit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_LIMIT |-> m_tdata[6:0] == ITER_MAX)
    else $error("iteration limit reported at wrong count");

endmodule

bind grey_point_auto_white_balance gpawb_checker #(.MAX_ITERATIONS(MAX_ITERATIONS)) u_chk (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ----- tb/tb.sv -----
// Self-checking testbench for the grey-point auto white balance block.
// Drives pixel loads and readouts on the input stream and checks each result
// against an in-bench model of the balancing loop. Needs gpawb_pkg and the RTL.
`timescale 1ns / 1ps
module tb;
  import gpawb_pkg::*;

  // A small image store keeps the full-image test short.
  localparam int NPIX  = 256;
  localparam int NITER = 100;

  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  iterations;
    logic [15:0] gain_b;
    logic [15:0] gain_g;
    logic [15:0] gain_r;
    logic [7:0]  pix_b;
    logic [7:0]  pix_g;
    logic [7:0]  pix_r;
  } awb_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;
  logic [1:0]  m_tuser;

  // Model of the block.
  logic [23:0] stored_img [NPIX];
  int          stored_cnt;
  int          work_gain [3];
  int          used_gain [3];
  bit          img_closed;
  int          grey_thr;
  int          step_size;

  awb_result_t pending_results [$];
  int          send_idle_pct;
  int          recv_idle_pct;
  int          errors;

  grey_point_auto_white_balance #(.MAX_PIXELS(NPIX), .MAX_ITERATIONS(NITER)) u_top (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tlast(s_tlast), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  always #5 clk = ~clk;

  initial begin
    #100_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int scale_channel(int val, int gain);
    int prod;
    prod = val * gain;
    if (prod <= 0) return 0;
    prod = prod >>> 12;
    return (prod > 255) ? 255 : prod;
  endfunction

  function automatic longint absl(longint x);
    return (x < 0) ? -x : x;
  endfunction

  function automatic int clip16(int x);
    if (x > 32767) return 32767;
    if (x < -32768) return -32768;
    return x;
  endfunction

  // Runs the iterative grey-point search over the stored image.
  function automatic void balance_image(output logic [1:0] st, output int iter_out);
    longint sum_u, sum_v, au, av, sel, yy, uu, vv;
    int     n, chan, delta, bb, gg, rr;
    for (int c = 0; c < 3; c++) begin
      work_gain[c] = 4096;
      used_gain[c] = 4096;
    end
    for (int j = 0; j < NITER; j++) begin
      used_gain = work_gain;
      sum_u = 0;
      sum_v = 0;
      n = 0;
      for (int i = 0; i < stored_cnt; i++) begin
        bb = scale_channel(stored_img[i][7:0], work_gain[0]);
        gg = scale_channel(stored_img[i][15:8], work_gain[1]);
        rr = scale_channel(stored_img[i][23:16], work_gain[2]);
        yy = 299 * rr + 587 * gg + 114 * bb;
        uu = -299 * rr - 587 * gg + 886 * bb;
        vv = 701 * rr - 587 * gg - 114 * bb;
        if ((absl(uu) + absl(vv)) * 4096 < longint'(grey_thr) * yy) begin
          sum_u += uu;
          sum_v += vv;
          n++;
        end
      end
      iter_out = j;
      if (n == 0) begin
        st = ST_NO_GREY;
        return;
      end
      au = absl(sum_u);
      av = absl(sum_v);
      if (au > av || (au == av && au != 0)) begin
        chan = 0;
        sel = sum_u;
      end else if (au < av) begin
        chan = 2;
        sel = sum_v;
      end else begin
        st = ST_CONVERGED;
        return;
      end
      if (absl(sel) >= longint'(n) * 800) delta = 2 * step_size;
      else if (absl(sel) < longint'(n) * 150) begin
        st = ST_CONVERGED;
        return;
      end else delta = step_size >> 1;
      if (sel > 0) delta = -delta;
      work_gain[chan] = clip16(work_gain[chan] + delta);
    end
    iter_out = NITER;
    st = ST_LIMIT;
  endfunction

  // Updates the model for one accepted item and queues any result it causes.
  function automatic void model_item(logic op, logic [7:0] b, logic [7:0] g,
                                     logic [7:0] r, logic last, logic [13:0] idx);
    awb_result_t res;
    logic [1:0]  st;
    int          it;
    res = '0;
    if (op == OP_LOAD) begin
      if (img_closed) begin
        img_closed = 1'b0;
        stored_cnt = 0;
        for (int c = 0; c < 3; c++) begin
          work_gain[c] = 4096;
          used_gain[c] = 4096;
        end
      end
      if (stored_cnt < NPIX) begin
        stored_img[stored_cnt] = {r, g, b};
        stored_cnt++;
      end
      if (!last) return;
      balance_image(st, it);
      img_closed = 1'b1;
      res.status = st;
      res.iterations = it[6:0];
      res.gain_b = work_gain[0][15:0];
      res.gain_g = work_gain[1][15:0];
      res.gain_r = work_gain[2][15:0];
    end else begin
      res.status = ST_READOUT;
      res.gain_b = used_gain[0][15:0];
      res.gain_g = used_gain[1][15:0];
      res.gain_r = used_gain[2][15:0];
      if (idx < stored_cnt) begin
        res.pix_b = 8'(scale_channel(stored_img[idx][7:0], used_gain[0]));
        res.pix_g = 8'(scale_channel(stored_img[idx][15:8], used_gain[1]));
        res.pix_r = 8'(scale_channel(stored_img[idx][23:16], used_gain[2]));
      end
    end
    pending_results.push_back(res);
  endfunction

  task automatic send_item(logic op, logic [7:0] b, logic [7:0] g, logic [7:0] r,
                           logic last, logic [13:0] idx);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tlast  <= last;
    s_tdata  <= {2'b0, idx, r, g, b};
    do @(posedge clk); while (!s_tready);
    model_item(op, b, g, r, last, idx);
    @(negedge clk);
  endtask

  // Register writes happen only with the block idle.
  task automatic write_reg(logic [2:0] addr, logic [31:0] value);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == 3'(REG_THRESHOLD) * 3'd4) grey_thr = value[15:0];
    else step_size = value[11:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic pick_config();
    int t, s;
    case ($urandom_range(0, 9))
      0: t = 0;
      1: t = 65535;
      default: t = $urandom_range(600, 4000);
    endcase
    case ($urandom_range(0, 9))
      0: s = 0;
      1: s = 4095;
      default: s = $urandom_range(16, 512);
    endcase
    write_reg(3'(REG_THRESHOLD) * 3'd4, t);
    write_reg(3'(REG_GAIN_STEP) * 3'd4, s);
  endtask

  function automatic logic [7:0] clamp8(int x);
    return (x < 0) ? 8'd0 : (x > 255) ? 8'd255 : x[7:0];
  endfunction

  task automatic test_directed();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // Readout before any image: out of range, gains at one.
    send_item(OP_READ, 8'hFF, 8'hFF, 8'hFF, 1'b1, 14'd0);
    send_item(OP_READ, 8'h00, 8'h00, 8'h00, 1'b0, 14'h3FFF);
    // A black pixel alone is never grey.
    send_item(OP_LOAD, 8'd0, 8'd0, 8'd0, 1'b1, 14'h3FFF);
    send_item(OP_READ, 8'd0, 8'd0, 8'd0, 1'b0, 14'd0);
    // Neutral white converges at once.
    send_item(OP_LOAD, 8'd255, 8'd255, 8'd255, 1'b1, 14'd0);
    send_item(OP_READ, 8'd0, 8'd0, 8'd0, 1'b0, 14'd0);
    send_item(OP_READ, 8'd0, 8'd0, 8'd0, 1'b0, 14'd1);
    // Bluish then reddish casts lie beyond the default threshold, so no pixel is grey.
    for (int i = 0; i < 4; i++) send_item(OP_LOAD, 8'd150, 8'd120, 8'd110, i == 3, '0);
    send_item(OP_READ, '0, '0, '0, 1'b0, 14'd2);
    for (int i = 0; i < 4; i++) send_item(OP_LOAD, 8'd100, 8'd120, 8'd160, i == 3, '0);
    send_item(OP_READ, '0, '0, '0, 1'b0, 14'd3);
    // Zero threshold finds no grey pixel; large steps drive gains negative.
    write_reg(3'(REG_THRESHOLD) * 3'd4, 32'd0);
    send_item(OP_LOAD, 8'd128, 8'd128, 8'd128, 1'b1, '0);
    write_reg(3'(REG_THRESHOLD) * 3'd4, 32'd65535);
    write_reg(3'(REG_GAIN_STEP) * 3'd4, 32'd4095);
    send_item(OP_LOAD, 8'd255, 8'd0, 8'd0, 1'b0, '0);
    send_item(OP_LOAD, 8'd200, 8'd60, 8'd40, 1'b1, '0);
    send_item(OP_READ, '0, '0, '0, 1'b0, 14'd0);
    // A zero step never changes the gains, so this cast reaches the pass limit.
    write_reg(3'(REG_GAIN_STEP) * 3'd4, 32'd0);
    send_item(OP_LOAD, 8'd180, 8'd120, 8'd100, 1'b1, '0);
    write_reg(3'(REG_THRESHOLD) * 3'd4, 32'd1229);
    write_reg(3'(REG_GAIN_STEP) * 3'd4, 32'd128);
  endtask

  task automatic test_random_phase(int tx_idle, int rx_idle, int n_items);
    int sent, npix, base, bias_b, bias_r, nreads;
    send_idle_pct = tx_idle;
    recv_idle_pct = rx_idle;
    sent = 0;
    pick_config();
    while (sent < n_items) begin
      if ($urandom_range(0, 3) == 0) pick_config();
      if ($urandom_range(0, 9) == 0) begin
        send_item(OP_READ, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
                  14'($urandom));
        sent++;
      end
      npix = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
      base = $urandom_range(20, 230);
      bias_b = $urandom_range(0, 120) - 60;
      bias_r = $urandom_range(0, 120) - 60;
      for (int i = 0; i < npix; i++) begin
        if ($urandom_range(0, 9) == 0)
          send_item(OP_LOAD, 8'($urandom), 8'($urandom), 8'($urandom), i == npix - 1,
                    14'($urandom));
        else
          send_item(OP_LOAD,
                    clamp8(base + bias_b + $urandom_range(0, 16) - 8),
                    clamp8(base + $urandom_range(0, 16) - 8),
                    clamp8(base + bias_r + $urandom_range(0, 16) - 8),
                    i == npix - 1, 14'($urandom));
        sent++;
      end
      nreads = $urandom_range(0, 4);
      for (int i = 0; i < nreads; i++) begin
        send_item(OP_READ, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
                  ($urandom_range(0, 7) == 0) ? 14'($urandom) : 14'($urandom_range(0, npix + 3)));
        sent++;
      end
    end
  endtask

  // Fills the whole store; the extra last pixel is dropped but still starts balancing.
  task automatic test_full_image();
    int lvl;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    lvl = $urandom_range(1, 255);
    for (int i = 0; i <= NPIX; i++)
      send_item(OP_LOAD, 8'(lvl), 8'(lvl), 8'(lvl), i == NPIX, '0);
    send_item(OP_READ, '0, '0, '0, 1'b0, 14'h3FFF);
    send_item(OP_READ, '0, '0, '0, 1'b0, 14'd0);
  endtask

  always @(negedge clk) m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    awb_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h/%h", $time, m_tuser, m_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, m_tuser);
        check_field("iterations", want.iterations, m_tdata[6:0]);
        check_field("gain_blue", want.gain_b, m_tdata[22:7]);
        check_field("gain_green", want.gain_g, m_tdata[38:23]);
        check_field("gain_red", want.gain_r, m_tdata[54:39]);
        check_field("out_b", want.pix_b, m_tdata[62:55]);
        check_field("out_g", want.pix_g, m_tdata[70:63]);
        check_field("out_r", want.pix_r, m_tdata[78:71]);
      end
    end
  end

  initial begin
    errors = 0;
    stored_cnt = 0;
    img_closed = 1'b0;
    grey_thr = 1229;
    step_size = 128;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int c = 0; c < 3; c++) begin
      work_gain[c] = 4096;
      used_gain[c] = 4096;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_random_phase(33, 65, 300);
    test_random_phase(65, 33, 300);
    test_random_phase(0, 0, 300);
    test_full_image();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
